### rtl/dfr_pkg.sv
// Shared types, constants and the CRC-16/CCITT byte update for the packet deframer.
// Used by every module of the deframer; depends on nothing else.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [7:0]  SYNC_RESET = 8'd170;
  localparam logic [10:0] MAX_LENGTH_RESET = 11'd1024;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_CMD     = 3'd1,
    PH_SEQ     = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_CRC_HI  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LONG = 2'd3
  } kind_t;

  typedef enum logic {
    REG_SYNC_VALUE = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [10:0] max_length;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  command;
    logic [7:0]  sequence_res;
    logic [15:0] frame_length;
  } result_t;

  function automatic logic [15:0] dfr_crc_update(input logic [15:0] crc_in,
                                                 input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### rtl/dfr_cfg.sv
// Configuration registers of the deframer: sync byte and largest payload length.
// Depends on dfr_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module dfr_cfg import dfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  output cfg_t        cfg
);

  logic [7:0]  sync_value;
  logic [10:0] max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_VALUE: sync_value <= cfg_data[7:0];
        REG_MAX_LENGTH: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.sync_value = sync_value;
  assign cfg.max_length = max_length;

endmodule

### rtl/dfr_parser.sv
// Frame parser: phase state machine, header capture, payload count and running CRC.
// Produces at most one result per accepted byte. Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_parser import dfr_pkg::*; #(
  parameter logic [15:0] LIMIT = 16'd1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic [7:0]  held_command, held_command_next;
  logic [7:0]  held_sequence, held_sequence_next;
  logic [15:0] held_length, held_length_next;
  logic [10:0] payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [15:0] crc_step;
  logic [15:0] limit;
  logic [15:0] length_full;
  logic [10:0] count_inc;

  assign crc_step    = dfr_crc_update(running_crc, rx_byte);
  assign limit       = ({5'd0, cfg.max_length} > LIMIT) ? LIMIT : {5'd0, cfg.max_length};
  assign length_full = {rx_byte, held_length[7:0]};
  assign count_inc   = payload_count + 11'd1;

  always_comb begin
    phase_next = phase;
    if (step) begin
      case (phase)
        PH_SYNC:    if (rx_byte == cfg.sync_value) phase_next = PH_CMD;
        PH_CMD:     phase_next = PH_SEQ;
        PH_SEQ:     phase_next = PH_LEN_LO;
        PH_LEN_LO:  phase_next = PH_LEN_HI;
        PH_LEN_HI: begin
          if (length_full > limit) begin
            phase_next = PH_SYNC;
          end else if (length_full == 16'd0) begin
            phase_next = PH_CRC_LO;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: if ({5'd0, count_inc} >= held_length) phase_next = PH_CRC_LO;
        PH_CRC_LO:  phase_next = PH_CRC_HI;
        PH_CRC_HI:  phase_next = PH_SYNC;
        default:    phase_next = PH_SYNC;
      endcase
    end
  end

  always_comb begin
    held_command_next  = held_command;
    held_sequence_next = held_sequence;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    running_crc_next   = running_crc;
    crc_low_byte_next  = crc_low_byte;
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.byte_index     = 10'd0;
    if (step) begin
      case (phase)
        PH_SYNC: begin
          if (rx_byte == cfg.sync_value) running_crc_next = CRC_INIT;
        end
        PH_CMD: begin
          held_command_next = rx_byte;
          running_crc_next  = crc_step;
        end
        PH_SEQ: begin
          held_sequence_next = rx_byte;
          running_crc_next   = crc_step;
        end
        PH_LEN_LO: begin
          held_length_next = {8'd0, rx_byte};
          running_crc_next = crc_step;
        end
        PH_LEN_HI: begin
          held_length_next   = length_full;
          running_crc_next   = crc_step;
          payload_count_next = 11'd0;
          if (length_full > limit) begin
            res_valid = 1'b1;
            res.kind  = KIND_LONG;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next   = crc_step;
          payload_count_next = count_inc;
          res_valid          = 1'b1;
          res.kind           = KIND_DATA;
          res.data_byte      = rx_byte;
          res.byte_index     = payload_count[9:0];
        end
        PH_CRC_LO: begin
          crc_low_byte_next = rx_byte;
        end
        PH_CRC_HI: begin
          res_valid = 1'b1;
          res.kind  = ({rx_byte, crc_low_byte} == running_crc) ? KIND_GOOD : KIND_BAD;
        end
        default: ;
      endcase
    end
    res.command      = held_command_next;
    res.sequence_res = held_sequence_next;
    res.frame_length = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      held_command  <= 8'd0;
      held_sequence <= 8'd0;
      held_length   <= 16'd0;
      payload_count <= 11'd0;
      running_crc   <= CRC_INIT;
      crc_low_byte  <= 8'd0;
    end else begin
      phase         <= phase_next;
      held_command  <= held_command_next;
      held_sequence <= held_sequence_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
    end
  end

endmodule

### rtl/dfr_out_reg.sv
// Result register between the parser and the output channel.
// Holds one result until the consumer takes it. Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_out_reg import dfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out
);

  logic    valid_q;
  result_t data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= res_in;
    end
  end

  assign out_valid = valid_q;
  assign res_out   = data_q;

endmodule

### rtl/framed_packet_deframer_crc16_top.sv
// Packet deframer with CRC-16/CCITT check: top level joining configuration, parser
// and result register. Depends on dfr_pkg, dfr_cfg, dfr_parser and dfr_out_reg.
// A result is registered and appears on the output in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the input is not stalled; the parser state and CRC update on each accepted byte.
// Input is stalled only while the result register holds a request the consumer has not taken.
// Reset (synchronous, active high) empties the result register, restores register defaults
// and returns the parser to sync hunting.
`timescale 1ns / 1ps

module framed_packet_deframer_crc16_top import dfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [9:0]  byte_index,
  output logic [7:0]  command,
  output logic [7:0]  sequence_res,
  output logic [15:0] frame_length
);

  localparam logic [15:0] LIMIT = 16'(MAX_PAYLOAD);

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t res_out;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  dfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfr_parser #(
    .LIMIT (LIMIT)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  dfr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign kind         = res_out.kind;
  assign data_byte    = res_out.data_byte;
  assign byte_index   = res_out.byte_index;
  assign command      = res_out.command;
  assign sequence_res = res_out.sequence_res;
  assign frame_length = res_out.frame_length;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the result register is empty.");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DATA |-> {6'd0, byte_index} < frame_length)
    else $error("Payload byte index lies outside the frame length.");

  a_end_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0 && byte_index == 10'd0)
    else $error("Frame end request carries payload fields.");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("Result appeared without an accepted byte.");

endmodule

### sim/tb_framed_packet_deframer_crc16_top.sv
// Self-checking testbench for the CRC-16 packet deframer top level.
// Holds its own deframer predictor and random frame stimulus; depends on dfr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_framed_packet_deframer_crc16_top;
  import dfr_pkg::*;

  localparam int PAYLOAD_CAP = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_BYTES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [9:0]  byte_index;
  logic [7:0]  command;
  logic [7:0]  sequence_res;
  logic [15:0] frame_length;

  framed_packet_deframer_crc16_top #(.MAX_PAYLOAD(PAYLOAD_CAP)) DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .data_byte(data_byte), .byte_index(byte_index),
    .command(command), .sequence_res(sequence_res), .frame_length(frame_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0]  tx_bytes[$];
  result_t     pending_results[$];
  bit          idling = 1'b1;
  bit          in_fire = 1'b0;
  int          send_gap = 0;
  int          hold_gap = 0;
  int          cycle_count = 0;
  int          bytes_taken = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          n_data = 0;
  int          n_good = 0;
  int          n_bad = 0;
  int          n_long = 0;

  // Register values as seen by the predictor and as assumed by the frame generator.
  logic [7:0]  cur_sync = SYNC_RESET;
  logic [10:0] cur_max = MAX_LENGTH_RESET;
  logic [7:0]  gen_sync = SYNC_RESET;
  logic [10:0] gen_max = MAX_LENGTH_RESET;

  phase_t      st_phase = PH_SYNC;
  logic [7:0]  st_cmd = '0;
  logic [7:0]  st_seq = '0;
  logic [15:0] st_len = '0;
  logic [10:0] st_count = '0;
  logic [15:0] st_crc = CRC_INIT;
  logic [7:0]  st_crc_lo = '0;

  result_t     pred_res;
  bit          pred_made;
  result_t     want_res;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic int eff_limit(input logic [10:0] max_len);
    return (int'(max_len) > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(max_len);
  endfunction

  function automatic result_t frame_result(input kind_t k, input logic [7:0] d,
                                           input logic [9:0] idx);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.byte_index = idx;
    r.command = st_cmd;
    r.sequence_res = st_seq;
    r.frame_length = st_len;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, output bit made, output result_t r);
    made = 1'b0;
    r = '0;
    case (st_phase)
      PH_SYNC: begin
        if (b == cur_sync) begin
          st_crc = CRC_INIT;
          st_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        st_cmd = b;
        st_crc = crc16_step(st_crc, b);
        st_phase = PH_SEQ;
      end
      PH_SEQ: begin
        st_seq = b;
        st_crc = crc16_step(st_crc, b);
        st_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        st_len = {8'h00, b};
        st_crc = crc16_step(st_crc, b);
        st_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        st_len[15:8] = b;
        st_crc = crc16_step(st_crc, b);
        st_count = '0;
        if (int'(st_len) > eff_limit(cur_max)) begin
          st_phase = PH_SYNC;
          made = 1'b1;
          r = frame_result(KIND_LONG, 8'h00, 10'd0);
          n_long++;
        end else begin
          st_phase = (st_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        st_crc = crc16_step(st_crc, b);
        made = 1'b1;
        r = frame_result(KIND_DATA, b, st_count[9:0]);
        n_data++;
        st_count = st_count + 11'd1;
        if ({5'd0, st_count} >= st_len) begin
          st_phase = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        st_crc_lo = b;
        st_phase = PH_CRC_HI;
      end
      default: begin
        st_phase = PH_SYNC;
        made = 1'b1;
        if ({b, st_crc_lo} == st_crc) begin
          r = frame_result(KIND_GOOD, 8'h00, 10'd0);
          n_good++;
        end else begin
          r = frame_result(KIND_BAD, 8'h00, 10'd0);
          n_bad++;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count++;
    in_fire = !rst && in_valid && in_ready;
    if (!rst && cfg_wr_en) begin
      if (cfg_index == REG_SYNC_VALUE) begin
        cur_sync = cfg_data[7:0];
      end else begin
        cur_max = cfg_data;
      end
    end
    if (in_fire) begin
      bytes_taken++;
      deframe_byte(rx_byte, pred_made, pred_res);
      if (pred_made) begin
        pending_results.push_back(pred_res);
      end
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: kind %0d data %02h index %0d cmd %02h seq %02h len %0d",
                   kind, data_byte, byte_index, command, sequence_res, frame_length);
        end
      end else begin
        want_res = pending_results.pop_front();
        if (kind !== want_res.kind || data_byte !== want_res.data_byte ||
            byte_index !== want_res.byte_index || command !== want_res.command ||
            sequence_res !== want_res.sequence_res ||
            frame_length !== want_res.frame_length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected kind %0d data %02h index %0d cmd %02h seq %02h len %0d",
                     want_res.kind, want_res.data_byte, want_res.byte_index,
                     want_res.command, want_res.sequence_res, want_res.frame_length);
            $display("          actual   kind %0d data %02h index %0d cmd %02h seq %02h len %0d",
                     kind, data_byte, byte_index, command, sequence_res, frame_length);
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (tx_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else begin
        rx_byte <= tx_bytes.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_gap != 0) begin
      hold_gap--;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      hold_gap = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [10:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] sync_byte, input logic [10:0] max_len);
    write_reg(REG_SYNC_VALUE, {3'($urandom), sync_byte});
    write_reg(REG_MAX_LENGTH, max_len);
    gen_sync = sync_byte;
    gen_max = max_len;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (tx_bytes.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
    #1;
  endtask

  // A frame longer than the limit ends after its header. A nonzero cut keeps only
  // that many leading bytes, leaving a broken frame in the stream.
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] seq,
                             input logic [15:0] len, input bit corrupt, input int cut,
                             output int count);
    logic [7:0]  fr[$];
    logic [15:0] c;
    logic [7:0]  b;
    c = CRC_INIT;
    fr.push_back(gen_sync);
    fr.push_back(cmd);
    fr.push_back(seq);
    fr.push_back(len[7:0]);
    fr.push_back(len[15:8]);
    for (int i = 1; i < 5; i++) begin
      c = crc16_step(c, fr[i]);
    end
    if (int'(len) <= eff_limit(gen_max)) begin
      for (int i = 0; i < int'(len); i++) begin
        b = 8'($urandom);
        fr.push_back(b);
        c = crc16_step(c, b);
      end
      if (corrupt) begin
        c = c ^ 16'($urandom_range(1, 65535));
      end
      fr.push_back(c[7:0]);
      fr.push_back(c[15:8]);
    end
    if (cut > 0 && cut < fr.size()) begin
      fr = fr[0:cut-1];
    end
    foreach (fr[i]) begin
      tx_bytes.push_back(fr[i]);
    end
    count = fr.size();
  endtask

  function automatic logic [15:0] pick_length();
    int lim;
    int cap;
    lim = eff_limit(gen_max);
    cap = (lim > 40) ? 12 : lim;
    if ($urandom_range(0, 5) == 0) begin
      return 16'(cap);
    end
    return 16'($urandom_range(0, cap));
  endfunction

  task automatic run_random(input int budget);
    int added;
    int sel;
    int n;
    int lim;
    logic [7:0] b;
    added = 0;
    lim = eff_limit(gen_max);
    while (added < budget) begin
      sel = $urandom_range(0, 99);
      n = 0;
      if (sel < 60) begin
        queue_frame(8'($urandom), 8'($urandom), pick_length(), 1'b0, 0, n);
      end else if (sel < 72) begin
        queue_frame(8'($urandom), 8'($urandom), pick_length(), 1'b1, 0, n);
      end else if (sel < 84) begin
        queue_frame(8'($urandom), 8'($urandom),
                    $urandom_range(0, 1) ? 16'(lim + 1) : 16'($urandom_range(lim + 1, 65535)),
                    1'b0, 0, n);
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 4)) begin
          do begin
            b = 8'($urandom);
          end while (b == gen_sync);
          tx_bytes.push_back(b);
        end
      end else begin
        queue_frame(8'($urandom), 8'($urandom), pick_length(), 1'b0,
                    $urandom_range(1, 7), n);
      end
      added += n;
    end
  endtask

  initial begin
    int n;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    queue_frame(8'h00, 8'hFF, 16'd0, 1'b0, 0, n);
    queue_frame(8'hFF, 8'h00, 16'd1, 1'b0, 0, n);
    queue_frame(8'h12, 8'h34, 16'hFFFF, 1'b0, 0, n);
    queue_frame(8'h5A, 8'hA5, 16'd0, 1'b1, 0, n);
    wait_drained();

    // Stop after the low length byte, then shrink the limit before the high byte arrives.
    queue_frame(8'h81, 8'h7E, 16'd1, 1'b0, 4, n);
    wait_drained();
    write_reg(REG_MAX_LENGTH, 11'd0);
    gen_max = 11'd0;
    tx_bytes.push_back(8'h00);
    run_random(PHASE_BYTES);
    wait_drained();

    set_config(8'h00, 11'd2047);
    queue_frame(8'($urandom), 8'($urandom), 16'(PAYLOAD_CAP + 1), 1'b0, 0, n);
    run_random(PHASE_BYTES);
    wait_drained();

    set_config(8'hFF, 11'd1);
    run_random(PHASE_BYTES);
    wait_drained();

    set_config(8'($urandom), 11'($urandom_range(2, 40)));
    run_random(PHASE_BYTES);
    wait_drained();

    idling = 1'b0;
    set_config(8'h7E, MAX_LENGTH_RESET);
    run_random(PHASE_BYTES);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Run took %0d bytes and checked %0d results under six register settings.",
             bytes_taken, results_seen);
    $display("Predicted %0d payload bytes, %0d good, %0d bad CRC, %0d oversized; %0d mismatches.",
             n_data, n_good, n_bad, n_long, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/dfr_pkg.sv
rtl/dfr_cfg.sv
rtl/dfr_parser.sv
rtl/dfr_out_reg.sv
rtl/framed_packet_deframer_crc16_top.sv
sim/tb_framed_packet_deframer_crc16_top.sv
